// ===== design/charset_byte_to_code_point_decoder_unit_macros.svh =====
// Assertion helpers used by the decoder back end (cbd_back).
`ifndef CHARSET_BYTE_TO_CODE_POINT_DECODER_UNIT_MACROS_SVH
`define CHARSET_BYTE_TO_CODE_POINT_DECODER_UNIT_MACROS_SVH

// Expression holds at every rising clock edge outside reset.
`define CBD_ASSERT(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define CBD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/cbd_pkg.sv =====
package cbd_pkg;

  localparam int unsigned QUEUE_DEPTH = 4;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 21;
  localparam int unsigned SB_W   = 16;
  localparam int unsigned PART_W = 15;

  localparam logic [CP_W-1:0] CP_MAX        = 21'h10FFFF;
  localparam logic [CP_W-1:0] SURR_LO       = 21'h00D800;
  localparam logic [CP_W-1:0] SURR_HI       = 21'h00E000;
  localparam logic [CP_W-1:0] NONCHAR_LO    = 21'h00FDD0;
  localparam logic [CP_W-1:0] NONCHAR_HI    = 21'h00FDF0;
  localparam logic [14:0]     NONCHAR_TAIL  = 15'h7FFF;
  localparam logic [CP_W-1:0] MIN_CODE_2B   = 21'h000080;
  localparam logic [CP_W-1:0] MIN_CODE_3B   = 21'h000800;
  localparam logic [CP_W-1:0] MIN_CODE_4B   = 21'h010000;
  localparam logic [5:0]      CONT_MASK     = 6'h3F;

  typedef enum logic [1:0] {
    ENC_UTF8   = 2'd0,
    ENC_LATIN1 = 2'd1,
    ENC_LATIN9 = 2'd2,
    ENC_CP1252 = 2'd3
  } encoding_e;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_INVALID    = 2'd1,
    ERR_INCOMPLETE = 2'd2
  } err_kind_e;

  typedef enum logic [2:0] {
    BC_ASCII = 3'd0,
    BC_CONT  = 3'd1,
    BC_LEAD2 = 3'd2,
    BC_LEAD3 = 3'd3,
    BC_LEAD4 = 3'd4,
    BC_BAD   = 3'd5
  } byte_class_e;

  // Sequence length class as kept in the back end
  localparam logic [1:0] LEN_NONE = 2'd0;
  localparam logic [1:0] LEN_2B   = 2'd1;
  localparam logic [1:0] LEN_3B   = 2'd2;
  localparam logic [1:0] LEN_4B   = 2'd3;

  typedef struct packed {
    logic              eoi;
    encoding_e         enc;
    byte_class_e       cls;
    logic [BYTE_W-1:0] data;
    logic [SB_W-1:0]   sb_cp;
  } item_t;

  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            has;
    err_kind_e       err;
  } result_t;

  localparam logic [SB_W-1:0] CP1252_HIGH [32] = '{
    16'h20AC, 16'h0081, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
    16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h008D, 16'h017D, 16'h008F,
    16'h0090, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
    16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h009D, 16'h017E, 16'h0178
  };

  function automatic byte_class_e classify(input logic [BYTE_W-1:0] b);
    byte_class_e c;
    if (!b[7])                    c = BC_ASCII;
    else if (b[7:6] == 2'b10)     c = BC_CONT;
    else if (b[7:5] == 3'b110)    c = BC_LEAD2;
    else if (b[7:4] == 4'b1110)   c = BC_LEAD3;
    else if (b[7:3] == 5'b11110)  c = BC_LEAD4;
    else                          c = BC_BAD;
    return c;
  endfunction

  function automatic logic [SB_W-1:0] map_latin9(input logic [BYTE_W-1:0] b);
    logic [SB_W-1:0] r;
    unique case (b)
      8'hA4:   r = 16'h20AC;
      8'hA6:   r = 16'h0160;
      8'hA8:   r = 16'h0161;
      8'hB4:   r = 16'h017D;
      8'hB8:   r = 16'h017E;
      8'hBC:   r = 16'h0152;
      8'hBD:   r = 16'h0153;
      8'hBE:   r = 16'h0178;
      default: r = {8'h00, b};
    endcase
    return r;
  endfunction

  function automatic logic [SB_W-1:0] map_cp1252(input logic [BYTE_W-1:0] b);
    logic [SB_W-1:0] r;
    if (b[7:5] == 3'b100) r = CP1252_HIGH[b[4:0]];
    else                  r = {8'h00, b};
    return r;
  endfunction

endpackage

// ===== design/cbd_front.sv =====
module cbd_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [1:0]                 cfg_wdata_i,
  input  logic                       in_valid_i,
  input  logic [cbd_pkg::BYTE_W-1:0] in_data_i,
  input  logic                       in_last_i,
  output logic                       in_ready_o,
  input  logic                       q_full_i,
  output logic                       push_o,
  output cbd_pkg::item_t             push_item_o
);
  import cbd_pkg::*;

  encoding_e enc_q, enc_d;

  always_comb begin
    enc_d = enc_q;
    if (cfg_we_i) begin
      enc_d = encoding_e'(cfg_wdata_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enc_q <= ENC_UTF8;
    end else begin
      enc_q <= enc_d;
    end
  end

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  // Tag each beat with its class and its single-byte mapping
  always_comb begin
    push_item_o.eoi  = in_last_i;
    push_item_o.enc  = enc_q;
    push_item_o.cls  = classify(in_data_i);
    push_item_o.data = in_data_i;
    case (enc_q)
      ENC_LATIN9: push_item_o.sb_cp = map_latin9(in_data_i);
      ENC_CP1252: push_item_o.sb_cp = map_cp1252(in_data_i);
      default:    push_item_o.sb_cp = {8'h00, in_data_i};
    endcase
  end

endmodule

// ===== design/cbd_queue.sv =====
module cbd_queue #(
  parameter int unsigned Depth = cbd_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cbd_pkg::item_t push_item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output cbd_pkg::item_t head_o
);
  import cbd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  item_t           slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign head_o  = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

// ===== design/cbd_back.sv =====
`include "charset_byte_to_code_point_decoder_unit_macros.svh"

module cbd_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_valid_i,
  input  cbd_pkg::item_t   q_head_i,
  output logic             pop_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output cbd_pkg::result_t out_o
);
  import cbd_pkg::*;

  logic [PART_W-1:0] partial_q, partial_d;
  logic [1:0]        need_q, need_d;
  logic [1:0]        len_q, len_d;
  logic              resync_q, resync_d;
  logic              out_valid_q, out_valid_d;
  result_t           out_q, out_d;

  logic              emit;
  result_t           res;
  logic [CP_W-1:0]   v;
  logic [CP_W-1:0]   floor_cp;
  logic              flagged;
  logic              cut;

  assign pop_o = q_valid_i && (!out_valid_q || out_ready_i);

  assign v = {partial_q, q_head_i.data[5:0] & CONT_MASK};

  always_comb begin
    case (len_q)
      LEN_3B:  floor_cp = MIN_CODE_3B;
      LEN_4B:  floor_cp = MIN_CODE_4B;
      default: floor_cp = MIN_CODE_2B;
    endcase
  end

  assign flagged = (v < floor_cp) || (v > CP_MAX) ||
                   ((v >= SURR_LO) && (v < SURR_HI)) ||
                   ((v >= NONCHAR_LO) && (v < NONCHAR_HI)) ||
                   (v[15:1] == NONCHAR_TAIL);

  always_comb begin
    partial_d = partial_q;
    need_d    = need_q;
    len_d     = len_q;
    resync_d  = resync_q;
    emit      = 1'b0;
    cut       = 1'b0;
    res.cp    = '0;
    res.has   = 1'b0;
    res.err   = ERR_NONE;

    if (q_head_i.eoi) begin
      emit      = (need_q != 2'd0);
      res.err   = (need_q != 2'd0) ? ERR_INCOMPLETE : ERR_NONE;
      partial_d = '0;
      need_d    = 2'd0;
      len_d     = LEN_NONE;
      resync_d  = 1'b0;
    end else if (q_head_i.enc != ENC_UTF8) begin
      emit    = 1'b1;
      res.has = 1'b1;
      res.cp  = {5'd0, q_head_i.sb_cp};
    end else if ((need_q != 2'd0) && (q_head_i.cls == BC_CONT)) begin
      need_d = need_q - 2'd1;
      if (need_q == 2'd1) begin
        partial_d = '0;
        emit      = 1'b1;
        res.has   = 1'b1;
        res.cp    = v;
        res.err   = flagged ? ERR_INVALID : ERR_NONE;
      end else begin
        partial_d = v[PART_W-1:0];
      end
    end else begin
      // Drop an unfinished sequence and decode this beat as a lead
      if (need_q != 2'd0) begin
        cut       = 1'b1;
        partial_d = '0;
        need_d    = 2'd0;
        len_d     = LEN_NONE;
      end
      if (resync_q && ((q_head_i.cls == BC_CONT) || (q_head_i.cls == BC_BAD))) begin
        emit = 1'b0;
      end else begin
        resync_d = 1'b0;
        res.err  = cut ? ERR_INVALID : ERR_NONE;
        unique case (q_head_i.cls)
          BC_ASCII: begin
            res.has = 1'b1;
            res.cp  = {13'd0, q_head_i.data};
          end
          BC_LEAD2: begin
            partial_d = {10'd0, q_head_i.data[4:0]};
            need_d    = 2'd1;
            len_d     = LEN_2B;
          end
          BC_LEAD3: begin
            partial_d = {11'd0, q_head_i.data[3:0]};
            need_d    = 2'd2;
            len_d     = LEN_3B;
          end
          BC_LEAD4: begin
            partial_d = {12'd0, q_head_i.data[2:0]};
            need_d    = 2'd3;
            len_d     = LEN_4B;
          end
          default: begin
            res.err  = ERR_INVALID;
            resync_d = 1'b1;
          end
        endcase
        emit = res.has || (res.err != ERR_NONE);
      end
    end
  end

  // Hold the result until taken; load a new one only into a free slot
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (pop_o && emit) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      partial_q   <= '0;
      need_q      <= 2'd0;
      len_q       <= LEN_NONE;
      resync_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        partial_q <= partial_d;
        need_q    <= need_d;
        len_q     <= len_d;
        resync_q  <= resync_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `CBD_ASSERT(a_resync_no_open_seq, clk_i, rst_ni, !(resync_q && (need_q != 2'd0)), "resync with open sequence")
  `CBD_ASSERT(a_need_within_len, clk_i, rst_ni, (need_q <= len_q), "pending count exceeds sequence length")
  `CBD_ASSERT_NEXT(a_eoi_clears, clk_i, rst_ni, pop_o && q_head_i.eoi, (need_q == 2'd0) && !resync_q && (partial_q == '0), "end marker left state behind")
  `CBD_ASSERT(a_no_cp_without_flag, clk_i, rst_ni, !(out_valid_q && !out_q.has && (out_q.cp != '0)), "code point set without flag")

endmodule

// ===== design/charset_byte_to_code_point_decoder_unit.sv =====
// Path: a beat accepted from s_axis is written into the byte queue, decoded from the
// queue head and registered in the output register that drives m_axis.
// Throughput: one byte per cycle while the result port is not stalled; the back end's
// decode step sets this, and the byte queue absorbs a stalled result port until it fills.
// Reset (rst_ni low, asynchronous): encoding returns to UTF-8, all sequence and
// resync state clears, the queue and output register empty. No clearing pass.
module charset_byte_to_code_point_decoder_unit #(
  parameter int unsigned QueueDepth = cbd_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,      // encoding
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] data_byte
  input  logic        s_axis_tlast_i,   // end_of_input
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [20:0] code_point, [23:21] zero
  output logic [2:0]  m_axis_tuser_o    // [0] has_code_point, [2:1] error_kind
);
  import cbd_pkg::*;

  logic    q_full;
  logic    push;
  item_t   push_item;
  logic    pop;
  logic    q_valid;
  item_t   q_head;
  result_t res;

  cbd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid_i),
    .in_data_i   (s_axis_tdata_i),
    .in_last_i   (s_axis_tlast_i),
    .in_ready_o  (s_axis_tready_o),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_item_o (push_item)
  );

  cbd_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (q_head)
  );

  cbd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_head_i    (q_head),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_o       (res)
  );

  assign m_axis_tdata_o = {3'b000, res.cp};
  assign m_axis_tuser_o = {res.err, res.has};

endmodule

// ===== tb/charset_byte_to_code_point_decoder_unit_tb.sv =====
module charset_byte_to_code_point_decoder_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import cbd_pkg::*;

  typedef struct packed {
    encoding_e  enc;
    logic [7:0] data;
    logic       last;
    logic       fixed;
    result_t    want;
  } beat_row_t;

  localparam result_t NOTHING = '{21'h0, 1'b0, ERR_NONE};

  localparam int unsigned NUM_ROWS = 26;
  localparam beat_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{ENC_UTF8,   8'h00, 1'b0, 1'b1, '{21'h000000, 1'b1, ERR_NONE}},
    '{ENC_UTF8,   8'h7F, 1'b0, 1'b1, '{21'h00007F, 1'b1, ERR_NONE}},
    '{ENC_UTF8,   8'h80, 1'b0, 1'b1, '{21'h000000, 1'b0, ERR_INVALID}},
    '{ENC_UTF8,   8'hFF, 1'b0, 1'b0, NOTHING},
    '{ENC_UTF8,   8'hC3, 1'b0, 1'b0, NOTHING},
    '{ENC_UTF8,   8'hA9, 1'b0, 1'b0, NOTHING},
    '{ENC_UTF8,   8'hC0, 1'b0, 1'b0, NOTHING},
    '{ENC_UTF8,   8'h80, 1'b0, 1'b1, '{21'h000000, 1'b1, ERR_INVALID}},
    '{ENC_UTF8,   8'hF7, 1'b0, 1'b0, NOTHING},
    '{ENC_UTF8,   8'hBF, 1'b0, 1'b0, NOTHING},
    '{ENC_UTF8,   8'hBF, 1'b0, 1'b0, NOTHING},
    '{ENC_UTF8,   8'hBF, 1'b0, 1'b1, '{21'h1FFFFF, 1'b1, ERR_INVALID}},
    '{ENC_UTF8,   8'hED, 1'b0, 1'b0, NOTHING},
    '{ENC_UTF8,   8'hA0, 1'b0, 1'b0, NOTHING},
    '{ENC_UTF8,   8'h80, 1'b0, 1'b1, '{21'h00D800, 1'b1, ERR_INVALID}},
    '{ENC_UTF8,   8'hE2, 1'b0, 1'b0, NOTHING},
    '{ENC_UTF8,   8'h41, 1'b0, 1'b1, '{21'h000041, 1'b1, ERR_INVALID}},
    '{ENC_UTF8,   8'hC3, 1'b0, 1'b0, NOTHING},
    '{ENC_UTF8,   8'hF8, 1'b0, 1'b1, '{21'h000000, 1'b0, ERR_INVALID}},
    '{ENC_UTF8,   8'hE2, 1'b0, 1'b0, NOTHING},
    '{ENC_UTF8,   8'h00, 1'b1, 1'b1, '{21'h000000, 1'b0, ERR_INCOMPLETE}},
    '{ENC_LATIN1, 8'hFF, 1'b0, 1'b1, '{21'h0000FF, 1'b1, ERR_NONE}},
    '{ENC_LATIN9, 8'hA4, 1'b0, 1'b0, NOTHING},
    '{ENC_CP1252, 8'h80, 1'b0, 1'b1, '{21'h0020AC, 1'b1, ERR_NONE}},
    '{ENC_CP1252, 8'h9F, 1'b0, 1'b1, '{21'h000178, 1'b1, ERR_NONE}},
    '{ENC_CP1252, 8'hFF, 1'b1, 1'b0, NOTHING}
  };

  localparam logic [15:0] WIN1252_UPPER [32] = '{
    16'h20AC, 16'h0081, 16'h201A, 16'h0192, 16'h201E, 16'h2026, 16'h2020, 16'h2021,
    16'h02C6, 16'h2030, 16'h0160, 16'h2039, 16'h0152, 16'h008D, 16'h017D, 16'h008F,
    16'h0090, 16'h2018, 16'h2019, 16'h201C, 16'h201D, 16'h2022, 16'h2013, 16'h2014,
    16'h02DC, 16'h2122, 16'h0161, 16'h203A, 16'h0153, 16'h009D, 16'h017E, 16'h0178
  };

  localparam int unsigned NUM_BOUNDARY = 20;
  localparam logic [20:0] BOUNDARY_CPS [NUM_BOUNDARY] = '{
    21'h00007F, 21'h000080, 21'h0007FF, 21'h000800, 21'h00D7FF,
    21'h00D800, 21'h00DFFF, 21'h00E000, 21'h00FDCF, 21'h00FDD0,
    21'h00FDEF, 21'h00FDF0, 21'h00FFFD, 21'h00FFFE, 21'h00FFFF,
    21'h010000, 21'h01FFFE, 21'h10FFFF, 21'h110000, 21'h1FFFFF
  };

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        cfg_we_i        = 1'b0;
  logic [1:0]  cfg_wdata_i     = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i  = '0;
  logic        s_axis_tlast_i  = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [23:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;

  // Decoder state as seen by the predictor
  encoding_e   cur_enc    = ENC_UTF8;
  logic [14:0] seq_bits   = '0;
  logic [1:0]  conts_left = '0;
  logic [1:0]  len_class  = LEN_NONE;
  logic        dropping   = 1'b0;

  result_t     pending_code_points [$];
  int unsigned mismatch_count = 0;
  int unsigned beats_sent     = 0;
  int unsigned stall_left     = 0;
  bit          no_idle        = 1'b0;

  charset_byte_to_code_point_decoder_unit dut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [15:0] latin9_char(input logic [7:0] b);
    case (b)
      8'hA4:   return 16'h20AC;
      8'hA6:   return 16'h0160;
      8'hA8:   return 16'h0161;
      8'hB4:   return 16'h017D;
      8'hB8:   return 16'h017E;
      8'hBC:   return 16'h0152;
      8'hBD:   return 16'h0153;
      8'hBE:   return 16'h0178;
      default: return {8'h00, b};
    endcase
  endfunction

  function automatic bit is_suspect(input logic [20:0] v, input logic [1:0] cls);
    logic [20:0] lowest;
    case (cls)
      LEN_3B:  lowest = 21'h000800;
      LEN_4B:  lowest = 21'h010000;
      default: lowest = 21'h000080;
    endcase
    return v < lowest || v > 21'h10FFFF ||
           (v >= 21'h00D800 && v < 21'h00E000) ||
           (v >= 21'h00FDD0 && v < 21'h00FDF0) ||
           v[15:1] == 15'h7FFF;
  endfunction

  // Advance the predicted state by one beat; return 1 when a result is due.
  function automatic bit decode_byte(input logic [7:0] b, input logic eoi, output result_t r);
    logic [20:0] v;
    bit          cut;
    cut = 1'b0;
    r   = NOTHING;
    if (eoi) begin
      r.err      = (conts_left != 0) ? ERR_INCOMPLETE : ERR_NONE;
      cut        = conts_left != 0;
      seq_bits   = '0;
      conts_left = '0;
      len_class  = LEN_NONE;
      dropping   = 1'b0;
      return cut;
    end
    case (cur_enc)
      ENC_LATIN1: begin
        r.cp = {13'h0, b};
        r.has = 1'b1;
        return 1'b1;
      end
      ENC_LATIN9: begin
        r.cp = {5'h0, latin9_char(b)};
        r.has = 1'b1;
        return 1'b1;
      end
      ENC_CP1252: begin
        r.cp = (b[7:5] == 3'b100) ? {5'h0, WIN1252_UPPER[b[4:0]]} : {13'h0, b};
        r.has = 1'b1;
        return 1'b1;
      end
      default: ;
    endcase
    if (conts_left != 0) begin
      if (b[7:6] == 2'b10) begin
        v = {seq_bits, b[5:0]};
        conts_left = conts_left - 2'd1;
        if (conts_left != 0) begin
          seq_bits = v[14:0];
          return 1'b0;
        end
        seq_bits = '0;
        r.cp  = v;
        r.has = 1'b1;
        r.err = is_suspect(v, len_class) ? ERR_INVALID : ERR_NONE;
        return 1'b1;
      end
      // Drop the open sequence and decode this byte as a lead
      cut        = 1'b1;
      seq_bits   = '0;
      conts_left = '0;
      len_class  = LEN_NONE;
    end
    if (dropping) begin
      if (b[7:6] == 2'b10 || b >= 8'hF8) return 1'b0;
      dropping = 1'b0;
    end
    if (!b[7]) begin
      r.cp  = {13'h0, b};
      r.has = 1'b1;
    end else if (b[7:5] == 3'b110) begin
      seq_bits   = {10'h0, b[4:0]};
      conts_left = 2'd1;
      len_class  = LEN_2B;
    end else if (b[7:4] == 4'b1110) begin
      seq_bits   = {11'h0, b[3:0]};
      conts_left = 2'd2;
      len_class  = LEN_3B;
    end else if (b[7:3] == 5'b11110) begin
      seq_bits   = {12'h0, b[2:0]};
      conts_left = 2'd3;
      len_class  = LEN_4B;
    end else begin
      cut      = 1'b1;
      dropping = 1'b1;
    end
    if (cut) r.err = ERR_INVALID;
    return r.has || cut;
  endfunction

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_beat(input logic [7:0] d, input logic l, input logic fixed,
                           input result_t fixed_r);
    result_t pr;
    bit      due;
    if (!no_idle && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= d;
    s_axis_tlast_i  <= l;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    due = decode_byte(d, l, pr);
    if (fixed) pending_code_points.push_back(fixed_r);
    else if (due) pending_code_points.push_back(pr);
    beats_sent++;
  endtask

  // Write the encoding once the decoder has drained.
  task automatic set_encoding(input encoding_e e);
    s_axis_tvalid_i <= 1'b0;
    while (pending_code_points.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= e;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_enc = e;
  endtask

  task automatic send_utf8(input logic [20:0] v, input int unsigned n, input int unsigned keep);
    logic [7:0] seq [4];
    case (n)
      1: seq[0] = {1'b0, v[6:0]};
      2: begin
        seq[0] = {3'b110, v[10:6]};
        seq[1] = {2'b10, v[5:0]};
      end
      3: begin
        seq[0] = {4'b1110, v[15:12]};
        seq[1] = {2'b10, v[11:6]};
        seq[2] = {2'b10, v[5:0]};
      end
      default: begin
        seq[0] = {5'b11110, v[20:18]};
        seq[1] = {2'b10, v[17:12]};
        seq[2] = {2'b10, v[11:6]};
        seq[3] = {2'b10, v[5:0]};
      end
    endcase
    for (int unsigned k = 0; k < keep; k++) send_beat(seq[k], 1'b0, 1'b0, NOTHING);
  endtask

  task automatic utf8_chunk();
    int unsigned pick;
    int unsigned n;
    int unsigned shortest;
    logic [20:0] v;
    pick = $urandom_range(0, 99);
    if (pick < 30) begin
      send_beat(8'($urandom_range(0, 127)), 1'b0, 1'b0, NOTHING);
    end else if (pick < 70) begin
      if ($urandom_range(0, 2) == 0) begin
        v = BOUNDARY_CPS[$urandom_range(0, NUM_BOUNDARY - 1)];
        shortest = (v < 21'h80) ? 1 : (v < 21'h800) ? 2 : (v < 21'h10000) ? 3 : 4;
        n = $urandom_range(shortest, 4);
      end else begin
        n = $urandom_range(2, 4);
        v = (n == 2) ? 21'($urandom_range(0, 21'h7FF)) :
            (n == 3) ? 21'($urandom_range(0, 21'hFFFF)) : 21'($urandom_range(0, 21'h1FFFFF));
      end
      send_utf8(v, n, n);
    end else if (pick < 82) begin
      // Cut a sequence short; the next chunk decides how
      n = $urandom_range(2, 4);
      send_utf8(21'($urandom_range(0, 21'h1FFFFF)), n, $urandom_range(1, n - 1));
    end else if (pick < 95) begin
      send_beat(8'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                               : $urandom_range(128, 255)),
                1'b0, 1'b0, NOTHING);
    end else begin
      send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b0, NOTHING);
    end
  endtask

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      m_axis_tready_i <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!no_idle && $urandom_range(0, 9) == 0) begin
      m_axis_tready_i <= 1'b0;
      stall_left <= $urandom_range(0, 10);
    end else begin
      m_axis_tready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_code_points.size() == 0) begin
        report_mismatch("unexpected beat", 32'(m_axis_tdata_o), 0);
      end else begin
        want = pending_code_points.pop_front();
        if (m_axis_tdata_o !== {3'b000, want.cp})
          report_mismatch("code_point", 32'(m_axis_tdata_o), 32'(want.cp));
        if (m_axis_tuser_o[0] !== want.has)
          report_mismatch("has_code_point", 32'(m_axis_tuser_o[0]), 32'(want.has));
        if (m_axis_tuser_o[2:1] !== want.err)
          report_mismatch("error_kind", 32'(m_axis_tuser_o[2:1]), 32'(want.err));
      end
    end
  end

  initial begin
    encoding_e   plan;
    int unsigned goal;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int unsigned i = 0; i < NUM_ROWS; i++) begin
      if (i == 0 || DIRECTED_ROWS[i].enc != cur_enc) set_encoding(DIRECTED_ROWS[i].enc);
      send_beat(DIRECTED_ROWS[i].data, DIRECTED_ROWS[i].last, DIRECTED_ROWS[i].fixed,
                DIRECTED_ROWS[i].want);
    end

    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0:       plan = ENC_CP1252;
        1:       plan = ENC_UTF8;
        2:       plan = ENC_LATIN9;
        3:       plan = ENC_LATIN1;
        9:       plan = ENC_UTF8;
        default: plan = ($urandom_range(0, 9) < 6) ? ENC_UTF8 : encoding_e'($urandom_range(1, 3));
      endcase
      set_encoding(plan);
      no_idle = (ph == 9) || ($urandom_range(0, 4) == 0);
      goal = beats_sent + 90;
      while (beats_sent < goal) begin
        if (cur_enc == ENC_UTF8) utf8_chunk();
        else send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 31) == 0, 1'b0, NOTHING);
      end
    end

    s_axis_tvalid_i <= 1'b0;
    no_idle = 1'b1;
    while (pending_code_points.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (mismatch_count == 0 && pending_code_points.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
